@@ sv/png_uf_pkg.sv @@
package png_uf_pkg;

    localparam int MAX_ROW_BYTES = 16384;
    localparam int MAX_BPP       = 8;

    localparam int ROW_AW  = $clog2(MAX_ROW_BYTES);
    localparam int COL_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int SLOT_W  = $clog2(MAX_BPP);
    localparam int BPP_W   = 4;
    localparam int LEN_W   = 15;
    localparam int CFG_W   = 15;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;

    // register indexes on the configuration port
    localparam logic REG_BPP     = 1'b0;
    localparam logic REG_ROW_LEN = 1'b1;

    // filter kinds
    localparam logic [KIND_W-1:0] FILT_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] FILT_SUB     = 3'd1;
    localparam logic [KIND_W-1:0] FILT_UP      = 3'd2;
    localparam logic [KIND_W-1:0] FILT_AVG     = 3'd3;
    localparam logic [KIND_W-1:0] FILT_PAETH   = 3'd4;
    localparam logic [KIND_W-1:0] FILT_UNKNOWN = 3'd5;

    // one data byte handed from the front end to the reconstruction stage
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [ROW_AW-1:0] index;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic              use_prior;
        logic              last;
    } issue_t;

endpackage

@@ sv/png_uf_ram.sv @@
module png_uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/png_uf_ctrl.sv @@
module png_uf_ctrl
    import png_uf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              image_start,
    output logic              issue_valid,
    output issue_t            issue,
    output logic              window_clear
);

    logic [BPP_W-1:0]  bpp_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic              prior_valid_reg;
    logic              prior_valid_next;
    logic [SLOT_W-1:0] slot_cnt_reg [MAX_BPP];

    logic [COL_W-1:0]  col_eff;
    logic [COL_W-1:0]  col_m1;
    logic [COL_W-1:0]  len_eff;
    logic [SLOT_W-1:0] bpp_m1;
    logic              pv_eff;
    logic              is_filter;
    logic              last;

    // clamp the registers to their working range
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            bpp_m1 = '0;
        end
        else if (bpp_reg > BPP_W'(MAX_BPP))
        begin
            bpp_m1 = SLOT_W'(MAX_BPP - 1);
        end
        else
        begin
            bpp_m1 = SLOT_W'(bpp_reg - 1'b1);
        end

        if (len_reg == '0)
        begin
            len_eff = COL_W'(1);
        end
        else if (COL_W'(len_reg) > COL_W'(MAX_ROW_BYTES))
        begin
            len_eff = COL_W'(MAX_ROW_BYTES);
        end
        else
        begin
            len_eff = COL_W'(len_reg);
        end
    end

    always_comb
    begin
        col_eff   = image_start ? '0 : column_reg;
        pv_eff    = image_start ? 1'b0 : prior_valid_reg;
        is_filter = (col_eff == '0);
        col_m1    = column_reg - COL_W'(1);
        last      = (column_reg >= len_eff);

        column_next      = column_reg;
        kind_next        = kind_reg;
        prior_valid_next = prior_valid_reg;
        if (accept)
        begin
            if (is_filter)
            begin
                column_next      = COL_W'(1);
                kind_next        = (data_byte > BYTE_W'(FILT_PAETH)) ? FILT_UNKNOWN
                                                                     : data_byte[KIND_W-1:0];
                prior_valid_next = pv_eff;
            end
            else
            begin
                column_next      = last ? '0 : column_reg + COL_W'(1);
                prior_valid_next = last ? 1'b1 : pv_eff;
            end
        end
    end

    assign issue_valid     = accept && !is_filter;
    assign window_clear    = accept && is_filter;
    assign issue.data      = data_byte;
    assign issue.index     = col_m1[ROW_AW-1:0];
    assign issue.slot      = slot_cnt_reg[bpp_m1];
    assign issue.kind      = kind_reg;
    assign issue.use_prior = pv_eff;
    assign issue.last      = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg         <= BPP_W'(1);
            len_reg         <= LEN_W'(1);
            column_reg      <= '0;
            kind_reg        <= FILT_NONE;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BPP:     bpp_reg <= cfg_data[BPP_W-1:0];
                    REG_ROW_LEN: len_reg <= cfg_data[LEN_W-1:0];
                    default:     ;
                endcase
            end
            column_reg      <= column_next;
            kind_reg        <= kind_next;
            prior_valid_reg <= prior_valid_next;
        end
    end

    // one position counter per pixel width: counter k runs modulo k+1
    for (genvar k = 0; k < MAX_BPP; k++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slot_cnt_reg[k] <= '0;
            end
            else if (window_clear)
            begin
                slot_cnt_reg[k] <= '0;
            end
            else if (issue_valid)
            begin
                slot_cnt_reg[k] <= (slot_cnt_reg[k] == SLOT_W'(k)) ? '0
                                                                    : slot_cnt_reg[k] + 1'b1;
            end
        end
    end

endmodule

@@ sv/png_uf_recon.sv @@
module png_uf_recon
    import png_uf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              issue_valid,
    input  issue_t            issue,
    input  logic              window_clear,
    output logic              issue_ready,
    input  logic [BYTE_W-1:0] prior_rdata,
    output logic              prior_we,
    output logic [ROW_AW-1:0] prior_waddr,
    output logic [BYTE_W-1:0] prior_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last
);

    issue_t            s1_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [BYTE_W-1:0] left_reg   [MAX_BPP];
    logic [BYTE_W-1:0] upleft_reg [MAX_BPP];

    logic              out_free;
    logic              advance;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W:0]   pa;
    logic [BYTE_W:0]   pb;
    logic [BYTE_W+1:0] sum_ab;
    logic [BYTE_W+1:0] two_c;
    logic [BYTE_W+1:0] pc;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] result;

    assign out_free    = !out_valid_reg || out_ready;
    assign advance     = s1_valid_reg && out_free;
    assign issue_ready = !s1_valid_reg || out_free;

    always_comb
    begin
        a       = left_reg[s1_reg.slot];
        b       = s1_reg.use_prior ? prior_rdata : '0;
        c       = s1_reg.use_prior ? upleft_reg[s1_reg.slot] : '0;
        pa      = (b > c) ? {1'b0, b} - {1'b0, c} : {1'b0, c} - {1'b0, b};
        pb      = (a > c) ? {1'b0, a} - {1'b0, c} : {1'b0, c} - {1'b0, a};
        sum_ab  = {2'b00, a} + {2'b00, b};
        two_c   = {1'b0, c, 1'b0};
        pc      = (sum_ab > two_c) ? sum_ab - two_c : two_c - sum_ab;
        avg_sum = {1'b0, a} + {1'b0, b};

        // pick the nearest of left, up, upper-left; ties in that order
        priority if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc)
        begin
            pred = a;
        end
        else if ({1'b0, pb} <= pc)
        begin
            pred = b;
        end
        else
        begin
            pred = c;
        end

        unique case (s1_reg.kind)
            FILT_SUB:   result = s1_reg.data + a;
            FILT_UP:    result = s1_reg.data + b;
            FILT_AVG:   result = s1_reg.data + avg_sum[BYTE_W:1];
            FILT_PAETH: result = s1_reg.data + pred;
            default:    result = s1_reg.data;
        endcase
    end

    assign prior_we    = advance;
    assign prior_waddr = s1_reg.index;
    assign prior_wdata = result;

    always_ff @(posedge clk)
    begin
        if (issue_valid && issue_ready)
        begin
            s1_reg <= issue;
        end
        if (advance)
        begin
            out_byte_reg <= result;
            out_last_reg <= s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue_valid && issue_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // window clear at a filter byte wins over the write of the previous row's last byte
    for (genvar k = 0; k < MAX_BPP; k++)
    begin : g_win
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                left_reg[k]   <= '0;
                upleft_reg[k] <= '0;
            end
            else if (window_clear)
            begin
                left_reg[k]   <= '0;
                upleft_reg[k] <= '0;
            end
            else if (advance && s1_reg.slot == SLOT_W'(k))
            begin
                left_reg[k]   <= result;
                upleft_reg[k] <= b;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

@@ sv/png_scanline_unfilter_top.sv @@
// PNG scanline unfilter: rebuilds raw bytes from filtered, inflated scanline data.
// Input stream (s_*): one byte per transfer. The first byte of every row is the
// filter type and yields nothing; each further byte yields one output transfer.
// s_tuser marks the first byte of an image; it restarts the row and makes the
// prior row read as zero for the image's first row.
// Output stream (m_*): one reconstructed byte per transfer, m_tlast on the last
// byte of each row.
// Configuration: write bytes_per_pixel (index 0) and row_length (index 1) while
// idle; a write takes effect at the edge where cfg_we is high.
// Throughput: one byte per cycle while m_tready holds no byte back. The prior-row read
// happens at the input edge, together with the capture into the reconstruction stage;
// reconstruction into the output register follows once that register is free.
// The prior row lives in one 16384 x 8 memory, read when a byte enters and
// written back with the result as it enters the output register; a filter byte always separates
// two rows, so a read never meets a pending write to the same entry.
// Reset clears the row position, filter kind, windows and output valid; the
// prior-row memory is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its byte and one more byte
// waits in the reconstruction stage; s_tready drops only when both are full.
module png_scanline_unfilter_top
    import png_uf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] image_start
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] pixel_byte
    output logic              m_tlast    // row_end
);

    issue_t            issue;
    logic              issue_valid;
    logic              issue_ready;
    logic              window_clear;
    logic              accept;
    logic [BYTE_W-1:0] prior_rdata;
    logic              prior_we;
    logic [ROW_AW-1:0] prior_waddr;
    logic [BYTE_W-1:0] prior_wdata;

    // a transfer happens whenever a byte is offered and the reconstruction stage can take it
    assign s_tready = issue_ready;
    assign accept   = s_tvalid && issue_ready;

    png_uf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (s_tdata),
        .image_start  (s_tuser),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .window_clear (window_clear)
    );

    // read the prior-row byte as the data byte enters
    png_uf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .clk   (clk),
        .we    (prior_we),
        .waddr (prior_waddr),
        .wdata (prior_wdata),
        .re    (issue_valid),
        .raddr (issue.index),
        .rdata (prior_rdata)
    );

    png_uf_recon u_recon (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .window_clear (window_clear),
        .issue_ready  (issue_ready),
        .prior_rdata  (prior_rdata),
        .prior_we     (prior_we),
        .prior_waddr  (prior_waddr),
        .prior_wdata  (prior_wdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_last     (m_tlast)
    );

endmodule
